// ----- hdl/quoted_key_value_extractor_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quoted key/value extractor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUOTED_KEY_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define QUOTED_KEY_VALUE_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define QKVE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qkve assertion failed: same-cycle check");
`define QKVE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qkve assertion failed: next-cycle check");
`else
`define QKVE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define QKVE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/qkve_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkve_pkg
// Shared types and constants of the quoted key/value extractor.
// ----------------------------------------------------------------------------
package qkve_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_LEN_W   = 6;
   localparam int KEY_WORDS   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_3 = 3'd4;

   localparam logic [7:0]           QUOTE_CHAR = 8'h22;
   localparam logic [KEY_LEN_W-1:0] POS_SAT    = 6'd63;

   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_FOUND     = 2'd1,
      KIND_NOT_FOUND = 2'd2
   } kind_type;

endpackage

// ----- hdl/qkve_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkve_req_if / qkve_rsp_if
// Valid/ready channels for text bytes in and extracted results out.
// ----------------------------------------------------------------------------
interface qkve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface qkve_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic [1:0] kind;

   modport source (output valid, output value_byte, output kind, input ready);
   modport sink   (input valid, input value_byte, input kind, output ready);
endinterface

// ----- hdl/quoted_key_value_extractor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_key_value_extractor_top
// Finds the value of a configured key in a quoted-string text stream.
// ----------------------------------------------------------------------------
// Takes one text byte per clock while req.ready is high and returns each
// character of the value that follows the first key string equal to the
// programmed key, then a found status at the value's closing quote, or a
// not-found status on the byte that carries end_of_text. A byte is processed
// in the cycle it is accepted, and its result, if any, sits in a single
// output register; req.ready stays high as long as that register is empty or
// being drained, so a new transaction is taken every clock in that case.
// Program the key (key_length, then key_chars_0..3, low byte first) only
// while the stream is idle.
// ----------------------------------------------------------------------------
`include "quoted_key_value_extractor_top_assert.svh"

module quoted_key_value_extractor_top #(
   parameter int KEY_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   qkve_req_if.sink                            req,
   qkve_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [qkve_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qkve_pkg::CSR_DATA_W-1:0]     csr_data
);
   import qkve_pkg::*;

   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [7:0]           key_ff [KEY_MAX];
   logic [KEY_WORDS-1:0] word_we;

   logic                 inside_ff, inside_in;
   logic                 reading_ff, reading_in;
   logic                 matched_ff, matched_in;
   logic                 compare_ok_ff, compare_ok_in;
   logic [KEY_LEN_W-1:0] pos_ff, pos_in;
   logic                 finished_ff, finished_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           value_ff, value_in;
   kind_type             kind_ff, kind_in;

   logic                 accept;
   logic                 emit;
   logic                 found_now;
   logic                 is_quote;
   logic [KEY_MAX-1:0]   pos_hit;
   logic                 char_eq;

   // configuration
   always_comb begin
      word_we = '0;
      unique case (csr_index)
         CSR_KEY_CHARS_0: word_we[0] = csr_we;
         CSR_KEY_CHARS_1: word_we[1] = csr_we;
         CSR_KEY_CHARS_2: word_we[2] = csr_we;
         CSR_KEY_CHARS_3: word_we[3] = csr_we;
         default:         word_we = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
      end else if (csr_we && csr_index == CSR_KEY_LENGTH) begin
         key_length_ff <= csr_data[KEY_LEN_W-1:0];
      end
   end

   for (genvar k = 0; k < KEY_MAX; k++) begin : g_key
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[k] <= '0;
         end else if (word_we[k/8]) begin
            key_ff[k] <= csr_data[(k%8)*8 +: 8];
         end
      end
      assign pos_hit[k] = (pos_ff == KEY_LEN_W'(k)) && (key_ff[k] == req.text_byte);
   end

   assign char_eq  = |pos_hit;
   assign is_quote = (req.text_byte == QUOTE_CHAR);
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // search step
   always_comb begin
      inside_in     = inside_ff;
      reading_in    = reading_ff;
      matched_in    = matched_ff;
      compare_ok_in = compare_ok_ff;
      pos_in        = pos_ff;
      finished_in   = finished_ff;
      emit          = 1'b0;
      found_now     = 1'b0;
      value_in      = '0;
      kind_in       = KIND_CHAR;

      if (!finished_ff) begin
         if (is_quote) begin
            if (!inside_ff) begin
               inside_in     = 1'b1;
               pos_in        = '0;
               compare_ok_in = 1'b1;
            end else begin
               inside_in = 1'b0;
               if (!reading_ff) begin
                  matched_in = compare_ok_ff && (pos_ff == key_length_ff);
                  reading_in = 1'b1;
               end else begin
                  reading_in = 1'b0;
                  if (matched_ff) begin
                     emit        = 1'b1;
                     kind_in     = KIND_FOUND;
                     finished_in = 1'b1;
                     found_now   = 1'b1;
                  end
               end
            end
         end else if (inside_ff) begin
            if (!reading_ff) begin
               if (pos_ff >= key_length_ff || !char_eq) begin
                  compare_ok_in = 1'b0;
               end
               if (pos_ff != POS_SAT) begin
                  pos_in = pos_ff + KEY_LEN_W'(1);
               end
            end else if (matched_ff) begin
               emit     = 1'b1;
               value_in = req.text_byte;
            end
         end
      end

      if (req.end_of_text) begin
         if (!finished_ff && !found_now) begin
            emit     = 1'b1;
            value_in = '0;
            kind_in  = KIND_NOT_FOUND;
         end else if (!found_now) begin
            emit = 1'b0;
         end
         inside_in     = 1'b0;
         reading_in    = 1'b0;
         matched_in    = 1'b0;
         compare_ok_in = 1'b1;
         pos_in        = '0;
         finished_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         reading_ff    <= 1'b0;
         matched_ff    <= 1'b0;
         compare_ok_ff <= 1'b1;
         pos_ff        <= '0;
         finished_ff   <= 1'b0;
      end else if (accept) begin
         inside_ff     <= inside_in;
         reading_ff    <= reading_in;
         matched_ff    <= matched_in;
         compare_ok_ff <= compare_ok_in;
         pos_ff        <= pos_in;
         finished_ff   <= finished_in;
      end
   end

   // output register
   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         value_ff <= value_in;
         kind_ff  <= kind_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.value_byte = value_ff;
   assign rsp.kind       = kind_ff;

   `QKVE_ASSERT_SAME(a_no_rsp_after_found, clock, reset, accept && finished_ff, !emit)
   `QKVE_ASSERT_NEXT(a_eot_clears, clock, reset, accept && req.end_of_text, !finished_ff && !inside_ff && !reading_ff && compare_ok_ff && pos_ff == '0)
   `QKVE_ASSERT_NEXT(a_found_sets_done, clock, reset, accept && emit && kind_in == KIND_FOUND && !req.end_of_text, finished_ff && rsp_valid_ff)
   `QKVE_ASSERT_SAME(a_char_in_value, clock, reset, accept && emit && kind_in == KIND_CHAR, inside_ff && reading_ff && matched_ff)

endmodule
